[design/alsb_pkg.sv]
`default_nettype none

package alsb_pkg;

    localparam int WINDOW_CAP  = 64;
    localparam int LANE_COUNT  = 4;
    localparam int LANE_W      = 2;
    localparam int WARM_LIMIT  = 32;
    localparam int IDX_W       = (WINDOW_CAP > 1) ? $clog2(WINDOW_CAP) : 1;
    localparam int WIN_W       = $clog2(((WINDOW_CAP > WARM_LIMIT) ? WINDOW_CAP : WARM_LIMIT) + 1);
    localparam int USEC_W      = 32;
    localparam int SUM_W       = USEC_W + IDX_W;
    localparam int MEM_DEPTH   = LANE_COUNT * WINDOW_CAP;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int DEPTH_W     = 20;
    localparam int BKL_W       = 52;
    localparam int SLICE_W     = 16;
    localparam int TGT_W       = 26;
    localparam int PRESS_W     = TGT_W + 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 26;
    localparam int CFG_WS_W    = 7;
    localparam int AVG_STEPS   = USEC_W;
    localparam int SLICE_STEPS = SLICE_W;
    localparam int CNT_W       = $clog2(AVG_STEPS + 1);
    localparam int DIV_A_W     = (SUM_W > WIN_W + AVG_STEPS - 1) ? SUM_W : WIN_W + AVG_STEPS - 1;
    localparam int DIV_W       = (DIV_A_W > SLICE_W + PRESS_W) ? DIV_A_W : SLICE_W + PRESS_W;
    localparam int WS_RESET    = (WINDOW_CAP < 32) ? WINDOW_CAP : 32;

    localparam logic [USEC_W-1:0] COLD_AVG_US = USEC_W'(20);
    localparam logic [LANE_W-1:0] CLIENT_LANE = LANE_W'(3);

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BACKLOG_TARGET    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_BASE_SLICE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAINT_BASE_SLICE  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_MAX_SLICE  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_MAINT_MIN_SLICE   = CFG_IDX_W'(5);

    typedef struct packed {
        logic [LANE_W-1:0]  lane;
        logic [USEC_W-1:0]  exec_usec;
        logic [DEPTH_W-1:0] client_depth;
    } t_in_item;

    typedef struct packed {
        logic [USEC_W-1:0]  lane_avg_us;
        logic [USEC_W-1:0]  client_avg_us;
        logic [BKL_W-1:0]   client_backlog_us;
        logic [SLICE_W-1:0] client_slice_ms;
        logic [SLICE_W-1:0] maint_slice_ms;
    } t_out_item;

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_LOAD    = 11'b000_0000_0010,
        ST_DIV     = 11'b000_0000_0100,
        ST_AVG     = 11'b000_0000_1000,
        ST_BACKLOG = 11'b000_0001_0000,
        ST_PRESS   = 11'b000_0010_0000,
        ST_CMUL    = 11'b000_0100_0000,
        ST_DIVLD   = 11'b000_1000_0000,
        ST_CFIN    = 11'b001_0000_0000,
        ST_MMUL    = 11'b010_0000_0000,
        ST_MFIN    = 11'b100_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        DK_AVG = 2'd0,
        DK_CLI = 2'd1,
        DK_MNT = 2'd2
    } t_div_kind;

endpackage

`default_nettype wire

[design/adaptive_lane_slice_budget.sv]
// Adaptive lane slice budget. Each transfer on the input channel carries one
// execution-time sample, its lane and the client queue depth; one result
// transfer follows with the sampled lane's average, the client average, the
// client backlog and the effective client and maintenance slices. Every
// operation runs on one shared restoring divider (one quotient bit per cycle)
// and one shared 32x20 multiplier under a small sequencer, and the input is
// stalled while an item is in work. After the window update an item skips the
// average division when the lane is still warming up, and each slice is
// divided only when pressure applies and its base slice is non-zero. A
// finished result waits in an output register, so the next input can be
// taken while it is still stalled. Configuration writes are taken at any
// time but are meant for an idle block; writing the window size empties all
// lane windows at once.
`default_nettype none

module adaptive_lane_slice_budget (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  alsb_pkg::t_in_item               i_in,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output alsb_pkg::t_out_item              o_out,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [alsb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [alsb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int LANE_W  = alsb_pkg::LANE_W;
    localparam int IDX_W   = alsb_pkg::IDX_W;
    localparam int WIN_W   = alsb_pkg::WIN_W;
    localparam int USEC_W  = alsb_pkg::USEC_W;
    localparam int SUM_W   = alsb_pkg::SUM_W;
    localparam int ADDR_W  = alsb_pkg::ADDR_W;
    localparam int DEPTH_W = alsb_pkg::DEPTH_W;
    localparam int BKL_W   = alsb_pkg::BKL_W;
    localparam int SLICE_W = alsb_pkg::SLICE_W;
    localparam int TGT_W   = alsb_pkg::TGT_W;
    localparam int PRESS_W = alsb_pkg::PRESS_W;
    localparam int DIV_W   = alsb_pkg::DIV_W;
    localparam int CNT_W   = alsb_pkg::CNT_W;
    localparam int LANES   = alsb_pkg::LANE_COUNT;

    alsb_pkg::t_state    r_state, n_state;
    alsb_pkg::t_div_kind r_kind;

    logic [WIN_W-1:0]   r_ws;
    logic [TGT_W-1:0]   r_tgt;
    logic [SLICE_W-1:0] r_cbase, r_mbase, r_cmax, r_mmin;

    logic [SUM_W-1:0]   r_sum  [LANES];
    logic [WIN_W-1:0]   r_fill [LANES];
    logic [IDX_W-1:0]   r_widx [LANES];
    logic [USEC_W-1:0]  r_client_avg;

    logic [USEC_W-1:0]  r_mem [alsb_pkg::MEM_DEPTH];
    logic [USEC_W-1:0]  r_rd;
    logic [ADDR_W-1:0]  r_addr;

    logic [LANE_W-1:0]  r_lane;
    logic [USEC_W-1:0]  r_usec;
    logic [DEPTH_W-1:0] r_depth;

    logic [DIV_W-1:0]   r_rem, r_dsh;
    logic [USEC_W-1:0]  r_quo;
    logic [CNT_W-1:0]   r_cnt;

    logic [USEC_W-1:0]  r_lavg, r_cavg;
    logic [BKL_W-1:0]   r_prod, r_backlog;
    logic               r_press;
    logic [PRESS_W-1:0] r_num, r_den;
    logic [SLICE_W-1:0] r_cs, r_ms;

    logic                  r_out_valid;
    alsb_pkg::t_out_item   r_out;

    logic                  in_xfer, out_xfer, cfg_xfer, out_load;
    logic [ADDR_W-1:0]     in_addr;
    logic [WIN_W-1:0]      cfg_ws;
    logic [alsb_pkg::CFG_WS_W-1:0] cfg_ws_raw;

    logic                  lane_full, cold;
    logic [SUM_W-1:0]      sum_new;
    logic [WIN_W-1:0]      fill_new, warm, widx_inc;
    logic [IDX_W-1:0]      widx_new;

    logic                  div_ge;
    logic [DIV_W-1:0]      div_rem;
    logic [USEC_W-1:0]     avg_val;

    logic [PRESS_W-1:0]    tgt4, tgt3, press_b;
    logic                  press_now;
    logic [SLICE_W-1:0]    cmx, mmn, cdiff, mdiff;
    logic [USEC_W-1:0]     mul_a;
    logic [DEPTH_W-1:0]    mul_b;
    logic [BKL_W-1:0]      mul_p;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;
    assign cfg_xfer = i_cfg_valid && o_cfg_ready;
    assign out_load = (r_state == alsb_pkg::ST_MFIN) && (!r_out_valid || !i_out_stall);

    assign o_in_stall  = (r_state != alsb_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_addr = ADDR_W'(ADDR_W'(i_in.lane) * ADDR_W'(alsb_pkg::WINDOW_CAP)
                     + ADDR_W'(r_widx[i_in.lane]));

    assign cfg_ws_raw = i_cfg_data[alsb_pkg::CFG_WS_W-1:0];
    always_comb begin
        if (cfg_ws_raw == '0) begin
            cfg_ws = WIN_W'(1);
        end else if (int'(cfg_ws_raw) > alsb_pkg::WINDOW_CAP) begin
            cfg_ws = WIN_W'(alsb_pkg::WINDOW_CAP);
        end else begin
            cfg_ws = WIN_W'(cfg_ws_raw);
        end
    end

    // Window update of the sampled lane.
    assign lane_full = (r_fill[r_lane] >= r_ws);
    assign sum_new   = r_sum[r_lane] - (lane_full ? SUM_W'(r_rd) : '0) + SUM_W'(r_usec);
    assign fill_new  = lane_full ? r_fill[r_lane] : r_fill[r_lane] + WIN_W'(1);
    assign widx_inc  = WIN_W'(r_widx[r_lane]) + WIN_W'(1);
    assign widx_new  = (widx_inc >= r_ws) ? '0 : IDX_W'(widx_inc);
    assign warm      = (r_ws < WIN_W'(alsb_pkg::WARM_LIMIT)) ? r_ws : WIN_W'(alsb_pkg::WARM_LIMIT);
    assign cold      = (fill_new < warm);

    // Shared restoring divider step.
    assign div_ge  = (r_rem >= r_dsh);
    assign div_rem = div_ge ? r_rem - r_dsh : r_rem;
    assign avg_val = (r_quo == '0) ? USEC_W'(1) : r_quo;

    // Pressure terms.
    assign tgt4      = {r_tgt, 2'b00};
    assign tgt3      = PRESS_W'(r_tgt) + PRESS_W'({r_tgt, 1'b0});
    assign press_now = (r_tgt != '0) && (r_prod > BKL_W'(r_tgt));
    assign press_b   = (r_prod < BKL_W'(tgt4)) ? PRESS_W'(r_prod) : tgt4;
    assign cmx       = (r_cmax < r_cbase) ? r_cbase : r_cmax;
    assign mmn       = (r_mmin > r_mbase) ? r_mbase : r_mmin;
    assign cdiff     = cmx - r_cbase;
    assign mdiff     = r_mbase - mmn;

    // Shared multiplier operands.
    always_comb begin
        case (r_state)
            alsb_pkg::ST_CMUL: begin
                mul_a = USEC_W'(r_num);
                mul_b = DEPTH_W'(cdiff);
            end
            alsb_pkg::ST_MMUL: begin
                mul_a = USEC_W'(r_num);
                mul_b = DEPTH_W'(mdiff);
            end
            default: begin
                mul_a = r_cavg;
                mul_b = r_depth;
            end
        endcase
    end
    assign mul_p = BKL_W'(mul_a) * BKL_W'(mul_b);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            alsb_pkg::ST_IDLE:    if (in_xfer) n_state = alsb_pkg::ST_LOAD;
            alsb_pkg::ST_LOAD:    n_state = cold ? alsb_pkg::ST_AVG : alsb_pkg::ST_DIV;
            alsb_pkg::ST_DIV: begin
                if (r_cnt == CNT_W'(1)) begin
                    case (r_kind)
                        alsb_pkg::DK_CLI: n_state = alsb_pkg::ST_CFIN;
                        alsb_pkg::DK_MNT: n_state = alsb_pkg::ST_MFIN;
                        default:          n_state = alsb_pkg::ST_AVG;
                    endcase
                end
            end
            alsb_pkg::ST_AVG:     n_state = alsb_pkg::ST_BACKLOG;
            alsb_pkg::ST_BACKLOG: n_state = alsb_pkg::ST_PRESS;
            alsb_pkg::ST_PRESS:   n_state = alsb_pkg::ST_CMUL;
            alsb_pkg::ST_CMUL: begin
                n_state = (r_cbase != '0 && r_press) ? alsb_pkg::ST_DIVLD : alsb_pkg::ST_MMUL;
            end
            alsb_pkg::ST_DIVLD:   n_state = alsb_pkg::ST_DIV;
            alsb_pkg::ST_CFIN:    n_state = alsb_pkg::ST_MMUL;
            alsb_pkg::ST_MMUL: begin
                n_state = (r_mbase != '0 && r_press) ? alsb_pkg::ST_DIVLD : alsb_pkg::ST_MFIN;
            end
            alsb_pkg::ST_MFIN:    if (out_load) n_state = alsb_pkg::ST_IDLE;
            default:              n_state = alsb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= alsb_pkg::ST_IDLE;
            r_out_valid  <= 1'b0;
            r_ws         <= WIN_W'(alsb_pkg::WS_RESET);
            r_tgt        <= '0;
            r_cbase      <= '0;
            r_mbase      <= '0;
            r_cmax       <= '0;
            r_mmin       <= '0;
            r_client_avg <= alsb_pkg::COLD_AVG_US;
            for (int i = 0; i < LANES; i++) begin
                r_sum[i]  <= '0;
                r_fill[i] <= '0;
                r_widx[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_xfer) begin
                unique case (i_cfg_index)
                    alsb_pkg::CFG_WINDOW_SIZE: begin
                        r_ws         <= cfg_ws;
                        r_client_avg <= alsb_pkg::COLD_AVG_US;
                        for (int i = 0; i < LANES; i++) begin
                            r_sum[i]  <= '0;
                            r_fill[i] <= '0;
                            r_widx[i] <= '0;
                        end
                    end
                    alsb_pkg::CFG_BACKLOG_TARGET:    r_tgt   <= i_cfg_data[TGT_W-1:0];
                    alsb_pkg::CFG_CLIENT_BASE_SLICE: r_cbase <= i_cfg_data[SLICE_W-1:0];
                    alsb_pkg::CFG_MAINT_BASE_SLICE:  r_mbase <= i_cfg_data[SLICE_W-1:0];
                    alsb_pkg::CFG_CLIENT_MAX_SLICE:  r_cmax  <= i_cfg_data[SLICE_W-1:0];
                    alsb_pkg::CFG_MAINT_MIN_SLICE:   r_mmin  <= i_cfg_data[SLICE_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == alsb_pkg::ST_LOAD) begin
                r_sum[r_lane]  <= sum_new;
                r_fill[r_lane] <= fill_new;
                r_widx[r_lane] <= widx_new;
            end
            if (r_state == alsb_pkg::ST_AVG && r_lane == alsb_pkg::CLIENT_LANE) begin
                r_client_avg <= avg_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rd <= r_mem[in_addr];
        end
        if (r_state == alsb_pkg::ST_LOAD) begin
            r_mem[r_addr] <= r_usec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_lane  <= i_in.lane;
            r_usec  <= i_in.exec_usec;
            r_depth <= i_in.client_depth;
            r_addr  <= in_addr;
        end
        case (r_state)
            alsb_pkg::ST_LOAD: begin
                r_rem  <= DIV_W'(sum_new);
                r_dsh  <= DIV_W'(fill_new) << (alsb_pkg::AVG_STEPS - 1);
                r_cnt  <= CNT_W'(alsb_pkg::AVG_STEPS);
                r_kind <= alsb_pkg::DK_AVG;
                r_quo  <= cold ? alsb_pkg::COLD_AVG_US : '0;
            end
            alsb_pkg::ST_DIV: begin
                r_rem <= div_rem;
                r_dsh <= r_dsh >> 1;
                r_quo <= {r_quo[USEC_W-2:0], div_ge};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            alsb_pkg::ST_AVG: begin
                r_lavg <= avg_val;
                r_cavg <= (r_lane == alsb_pkg::CLIENT_LANE) ? avg_val : r_client_avg;
            end
            alsb_pkg::ST_BACKLOG: begin
                r_prod <= mul_p;
            end
            alsb_pkg::ST_PRESS: begin
                r_backlog <= r_prod;
                r_press   <= press_now;
                r_num     <= press_now ? press_b - PRESS_W'(r_tgt) : '0;
                r_den     <= tgt3;
            end
            alsb_pkg::ST_CMUL: begin
                r_prod <= mul_p;
                r_kind <= alsb_pkg::DK_CLI;
                r_cs   <= r_cbase;
            end
            alsb_pkg::ST_DIVLD: begin
                r_rem <= DIV_W'(r_prod);
                r_dsh <= DIV_W'(r_den) << (alsb_pkg::SLICE_STEPS - 1);
                r_cnt <= CNT_W'(alsb_pkg::SLICE_STEPS);
                r_quo <= '0;
            end
            alsb_pkg::ST_CFIN: begin
                r_cs <= r_cbase + r_quo[SLICE_W-1:0];
            end
            alsb_pkg::ST_MMUL: begin
                r_prod <= mul_p;
                r_kind <= alsb_pkg::DK_MNT;
                r_ms   <= r_mbase;
                r_quo  <= '0;
            end
            default: ;
        endcase
        if (out_load) begin
            r_out.lane_avg_us       <= r_lavg;
            r_out.client_avg_us     <= r_cavg;
            r_out.client_backlog_us <= r_backlog;
            r_out.client_slice_ms   <= r_cs;
            r_out.maint_slice_ms    <= r_ms - r_quo[SLICE_W-1:0];
        end
    end

    a_accept_starts_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == alsb_pkg::ST_LOAD))
        else $error("accepted transfer did not start the window update");

    a_result_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == alsb_pkg::ST_MFIN))
        else $error("result appeared outside the final step");

    a_avg_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.lane_avg_us != '0 && o_out.client_avg_us != '0))
        else $error("average of zero reported");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == alsb_pkg::ST_DIV) |-> (r_cnt != '0))
        else $error("divider ran past its last step");

endmodule

`default_nettype wire
